[hw/rtl/sha256sh_pkg.sv]
package sha256sh_pkg;

  typedef logic [7:0][31:0] word8_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_e;

  localparam logic ActAppend = 1'b0;
  localparam logic ActFinish = 1'b1;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;

  // Word 0 sits in the lowest slot.
  localparam word8_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hw/rtl/sha256sh_round.sv]
// One compression round plus the next message schedule word.
module sha256sh_round (
  input  sha256sh_pkg::word8_t work_i,
  input  logic [31:0]          k_i,
  input  logic [31:0]          w0_i,
  input  logic [31:0]          w1_i,
  input  logic [31:0]          w9_i,
  input  logic [31:0]          w14_i,
  output sha256sh_pkg::word8_t work_o,
  output logic [31:0]          w_new_o
);

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    ch  = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    maj = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    t1  = work_i[7] + sha256sh_pkg::big_sig1(work_i[4]) + ch + k_i + w0_i;
    t2  = sha256sh_pkg::big_sig0(work_i[0]) + maj;

    work_o[0] = t1 + t2;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t1;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];

    w_new_o = sha256sh_pkg::small_sig1(w14_i) + w9_i + sha256sh_pkg::small_sig0(w1_i) + w0_i;
  end

endmodule

[hw/rtl/sha256_stream_hasher.sv]
// SHA-256 hasher over a byte stream.
// The slave channel carries one beat per message byte: tuser low appends the
// byte in tdata, tuser high finishes the message (tdata is then ignored).
// An append beat is taken whenever the hasher is idle; the 64th byte of a
// block starts a compression: 64 rounds on the single shared round unit,
// then a fold of the result into the chaining words. tready stays low
// until both are done, so sustained input is set by the
// one-round-per-cycle round unit.
// A finish beat inserts the padding one byte per cycle through the same byte
// path (0x80, zeros, the 64-bit bit length), runs one or two compressions,
// and then presents the eight digest words on the master channel, word 0
// first, with tuser giving the word position and tlast on word 7.
// tready stays low from a finish until the last digest beat is taken; while
// the receiver stalls, the current word is simply held. After the last word
// the hasher is back in its reset state and ready for a new message.
// Reset clears the byte count and bit length and loads the initial hash
// values; the block is ready as soon as reset is released.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] message_byte
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last
);

  sha256sh_pkg::state_e state_q, state_d;

  // Control state.
  logic [5:0]  fill_q, fill_d;     // bytes in the current block
  logic [5:0]  round_q, round_d;
  logic [63:0] bits_q, bits_d;     // message length in bits so far
  logic        pad_q, pad_d;       // finishing a message
  logic        first_q, first_d;   // next pad byte is the 0x80 marker
  logic        extra_q, extra_d;   // marker did not leave room for the length
  logic        done_q, done_d;     // length written, last block in flight
  logic [2:0]  oidx_q, oidx_d;
  sha256sh_pkg::word8_t chain_q, chain_d;

  // Payload.
  logic [23:0] word_q, word_d;     // partial big-endian word
  logic [31:0] sched_q [16];       // message schedule window
  logic [31:0] sched_d [16];
  logic [63:0] len_q, len_d;       // length field, shifted out high byte first
  sha256sh_pkg::word8_t work_q, work_d;

  // Strobes.
  logic       data_acc;
  logic       fin_acc;
  logic       push_en;
  logic [7:0] push_byte;
  logic       len_phase;
  logic [7:0] pad_byte;
  logic       out_acc;

  sha256sh_pkg::word8_t work_next;
  logic [31:0]          w_new;

  sha256sh_round u_round (
    .work_i  (work_q),
    .k_i     (sha256sh_pkg::RoundK[round_q]),
    .w0_i    (sched_q[0]),
    .w1_i    (sched_q[1]),
    .w9_i    (sched_q[9]),
    .w14_i   (sched_q[14]),
    .work_o  (work_next),
    .w_new_o (w_new)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha256sh_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == sha256sh_pkg::ActFinish) begin
            state_d = sha256sh_pkg::ST_PAD;
          end else if (fill_q == sha256sh_pkg::LastByte) begin
            state_d = sha256sh_pkg::ST_COMP;
          end
        end
      end
      sha256sh_pkg::ST_PAD: begin
        if (fill_q == sha256sh_pkg::LastByte) begin
          state_d = sha256sh_pkg::ST_COMP;
        end
      end
      sha256sh_pkg::ST_COMP: begin
        if (round_q == sha256sh_pkg::LastRound) begin
          state_d = sha256sh_pkg::ST_ADD;
        end
      end
      sha256sh_pkg::ST_ADD: begin
        if (!pad_q) begin
          state_d = sha256sh_pkg::ST_IDLE;
        end else if (done_q) begin
          state_d = sha256sh_pkg::ST_OUT;
        end else begin
          state_d = sha256sh_pkg::ST_PAD;
        end
      end
      sha256sh_pkg::ST_OUT: begin
        if (m_axis_tready_i && oidx_q == sha256sh_pkg::LastWord) begin
          state_d = sha256sh_pkg::ST_IDLE;
        end
      end
      default: state_d = sha256sh_pkg::ST_IDLE;
    endcase
  end

  // Handshakes and byte path selection.
  always_comb begin
    s_axis_tready_o = (state_q == sha256sh_pkg::ST_IDLE);
    m_axis_tvalid_o = (state_q == sha256sh_pkg::ST_OUT);
    m_axis_tdata_o  = chain_q[0];
    m_axis_tuser_o  = oidx_q;
    m_axis_tlast_o  = (oidx_q == sha256sh_pkg::LastWord);

    data_acc = s_axis_tready_o && s_axis_tvalid_i && (s_axis_tuser_i == sha256sh_pkg::ActAppend);
    fin_acc  = s_axis_tready_o && s_axis_tvalid_i && (s_axis_tuser_i == sha256sh_pkg::ActFinish);
    out_acc  = m_axis_tvalid_o && m_axis_tready_i;

    // The length goes into the last eight bytes of the block that holds
    // the marker, or of the extra block when the marker came too late.
    len_phase = !first_q && !extra_q && (fill_q >= sha256sh_pkg::LenStart);
    if (first_q) begin
      pad_byte = sha256sh_pkg::PadMarker;
    end else if (len_phase) begin
      pad_byte = len_q[63:56];
    end else begin
      pad_byte = 8'h00;
    end

    push_en   = data_acc || (state_q == sha256sh_pkg::ST_PAD);
    push_byte = (state_q == sha256sh_pkg::ST_PAD) ? pad_byte : s_axis_tdata_i;
  end

  // Datapath next values.
  always_comb begin
    fill_d  = fill_q;
    round_d = round_q;
    bits_d  = bits_q;
    pad_d   = pad_q;
    first_d = first_q;
    extra_d = extra_q;
    done_d  = done_q;
    oidx_d  = oidx_q;
    chain_d = chain_q;
    word_d  = word_q;
    sched_d = sched_q;
    len_d   = len_q;
    work_d  = work_q;

    if (push_en) begin
      word_d = {word_q[15:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q[1:0] == 2'd3) begin
        for (int j = 0; j < 15; j++) begin
          sched_d[j] = sched_q[j + 1];
        end
        sched_d[15] = {word_q, push_byte};
      end
      if (fill_q == sha256sh_pkg::LastByte) begin
        work_d  = chain_q;
        round_d = 6'd0;
      end
    end

    if (data_acc) begin
      bits_d = bits_q + 64'd8;
    end

    if (fin_acc) begin
      len_d   = bits_q;
      bits_d  = 64'd0;
      pad_d   = 1'b1;
      first_d = 1'b1;
      extra_d = 1'b0;
      done_d  = 1'b0;
    end

    if (state_q == sha256sh_pkg::ST_PAD) begin
      first_d = 1'b0;
      if (first_q && fill_q >= sha256sh_pkg::LenStart) begin
        extra_d = 1'b1;
      end
      if (len_phase) begin
        len_d = {len_q[55:0], 8'h00};
        if (fill_q == sha256sh_pkg::LastByte) begin
          done_d = 1'b1;
        end
      end
      if (fill_q == sha256sh_pkg::LastByte) begin
        extra_d = 1'b0;
      end
    end

    if (state_q == sha256sh_pkg::ST_COMP) begin
      work_d  = work_next;
      round_d = round_q + 6'd1;
      for (int j = 0; j < 15; j++) begin
        sched_d[j] = sched_q[j + 1];
      end
      sched_d[15] = w_new;
    end

    if (state_q == sha256sh_pkg::ST_ADD) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end

    // Each taken digest word shifts out while the initial values shift in,
    // so the chain is back at its reset value after the last beat.
    if (out_acc) begin
      for (int i = 0; i < 7; i++) begin
        chain_d[i] = chain_q[i + 1];
      end
      chain_d[7] = sha256sh_pkg::InitHash[oidx_q];
      oidx_d     = oidx_q + 3'd1;
      if (oidx_q == sha256sh_pkg::LastWord) begin
        pad_d  = 1'b0;
        done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256sh_pkg::ST_IDLE;
      fill_q  <= 6'd0;
      round_q <= 6'd0;
      bits_q  <= 64'd0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      extra_q <= 1'b0;
      done_q  <= 1'b0;
      oidx_q  <= 3'd0;
      chain_q <= sha256sh_pkg::InitHash;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      round_q <= round_d;
      bits_q  <= bits_d;
      pad_q   <= pad_d;
      first_q <= first_d;
      extra_q <= extra_d;
      done_q  <= done_d;
      oidx_q  <= oidx_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    sched_q <= sched_d;
    len_q   <= len_d;
    work_q  <= work_d;
  end

`ifndef SYNTHESIS
  a_one_side_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a digest beat is pending");

  a_comp_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256sh_pkg::ST_COMP) |-> (fill_q == 6'd0))
    else $error("compression running on a partial block");

  a_comp_starts_at_round0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == sha256sh_pkg::ST_COMP) && ($past(state_q) != sha256sh_pkg::ST_COMP))
      |-> (round_q == 6'd0))
    else $error("compression did not start at round zero");

  a_chain_reloaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o)
      |=> ((state_q == sha256sh_pkg::ST_IDLE) && (chain_q == sha256sh_pkg::InitHash)
           && (bits_q == 64'd0)))
    else $error("hash state not restored after the last digest beat");
`endif

endmodule
